// ===== sv/ues_pkg.sv =====
`default_nettype none

package ues_pkg;

	// Word on the input channel
	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_end;
	} in_word_t;

	// Word on the result channel
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       text_done;
	} out_word_t;

	localparam int MaxKept   = 4;
	localparam int HeldDepth = 3;

	// Results of one input word, handed from the scan stage to the serializer
	typedef struct packed {
		logic [MaxKept-1:0][7:0] kept;
		logic [2:0]              kept_n;
		logic                    text_end;
	} grp_t;

	// Scan state plus the bytes kept so far for the current word
	typedef struct packed {
		logic [HeldDepth-1:0][7:0] held;
		logic [1:0]                held_n;
		logic [2:0]                seq_len;
		logic [MaxKept-1:0][7:0]   kept;
		logic [2:0]                kept_n;
	} scan_t;

	// Lead byte classes
	localparam logic [7:0] LeadMask2 = 8'hE0;
	localparam logic [7:0] LeadCode2 = 8'hC0;
	localparam logic [7:0] LeadMask3 = 8'hF0;
	localparam logic [7:0] LeadCode3 = 8'hE0;
	localparam logic [7:0] LeadMask4 = 8'hF8;
	localparam logic [7:0] LeadCode4 = 8'hF0;
	localparam logic [7:0] ContMask  = 8'h3F;
	localparam logic [7:0] Lead2Mask = 8'h1F;

	// Code point ranges that are removed
	localparam logic [20:0] PictLo = 21'h1F300;
	localparam logic [20:0] PictHi = 21'h1FAFF;
	localparam logic [20:0] SymLo  = 21'h02600;
	localparam logic [20:0] SymHi  = 21'h027BF;
	localparam logic [20:0] SelLo  = 21'h0FE00;
	localparam logic [20:0] SelHi  = 21'h0FE0F;

	function automatic logic drop_point(logic [20:0] cp);
		drop_point = (cp >= PictLo && cp <= PictHi) ||
			(cp >= SymLo && cp <= SymHi) ||
			(cp >= SelLo && cp <= SelHi);
	endfunction

	function automatic scan_t keep_byte(scan_t s, logic [7:0] b);
		scan_t r;
		r = s;
		if (s.kept_n < 3'(MaxKept)) begin
			r.kept[s.kept_n[1:0]] = b;
			r.kept_n = s.kept_n + 3'd1;
		end
		return r;
	endfunction

	// Feed one byte through the sequence collector
	function automatic scan_t take_byte(scan_t s, logic [7:0] b);
		scan_t             r;
		logic [3:0][7:0]   seq;
		logic [20:0]       cp;
		logic [2:0]        n;
		logic [2:0]        len;
		r   = s;
		seq = '0;
		cp  = '0;
		n   = '0;
		len = '0;
		if (s.held_n == 2'd0) begin
			if (!b[7]) begin
				r = keep_byte(r, b);
			end else begin
				if ((b & LeadMask2) == LeadCode2) len = 3'd2;
				else if ((b & LeadMask3) == LeadCode3) len = 3'd3;
				else if ((b & LeadMask4) == LeadCode4) len = 3'd4;
				if (len != 3'd0) begin
					r.held[0] = b;
					r.held_n  = 2'd1;
					r.seq_len = len;
				end
			end
		end else if ((({1'b0, s.held_n} + 3'd1) < s.seq_len) && (s.held_n < 2'd3)) begin
			r.held[s.held_n] = b;
			r.held_n = s.held_n + 2'd1;
		end else begin
			seq[0] = s.held[0];
			seq[1] = s.held[1];
			seq[2] = s.held[2];
			seq[s.held_n] = b;
			n = {1'b0, s.held_n} + 3'd1;
			case (n)
				3'd2: cp = {10'd0, 5'(seq[0] & Lead2Mask), 6'(seq[1] & ContMask)};
				3'd3: cp = {5'd0, seq[0][3:0], 6'(seq[1] & ContMask),
					6'(seq[2] & ContMask)};
				default: cp = {seq[0][2:0], 6'(seq[1] & ContMask),
					6'(seq[2] & ContMask), 6'(seq[3] & ContMask)};
			endcase
			r.held_n  = 2'd0;
			r.seq_len = 3'd0;
			if (!drop_point(cp)) begin
				for (int i = 0; i < 4; i++) begin
					if (i < int'(n)) r = keep_byte(r, seq[i]);
				end
			end
		end
		return r;
	endfunction

	// Process one input word; at end of text, drop unfinished leads and rescan
	function automatic scan_t scan_word(scan_t s, in_word_t w);
		scan_t                     r;
		logic [HeldDepth-1:0][7:0] rest;
		logic [1:0]                n;
		r = take_byte(s, w.in_byte);
		if (w.text_end) begin
			for (int k = 0; k < HeldDepth; k++) begin
				if (r.held_n != 2'd0) begin
					rest      = r.held;
					n         = r.held_n - 2'd1;
					r.held_n  = 2'd0;
					r.seq_len = 3'd0;
					for (int i = 0; i < HeldDepth - 1; i++) begin
						if (i < int'(n)) r = take_byte(r, rest[i+1]);
					end
				end
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/ues_scan.sv =====
`default_nettype none

module ues_scan (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             feed_valid,
	output logic                  feed_stall,
	input  wire ues_pkg::in_word_t feed_word,
	output logic                  grp_valid,
	output ues_pkg::grp_t         grp,
	input  wire logic             grp_take
);
	import ues_pkg::*;

	logic                      valid_s1;
	in_word_t                  word_s1;
	logic [HeldDepth-1:0][7:0] held_q;
	logic [1:0]                held_n_q;
	logic [2:0]                seq_len_q;
	logic                      adv;
	logic                      accept;
	scan_t                     cur;
	scan_t                     nxt;

	// Advance the input register when the serializer takes the group
	assign adv        = valid_s1 && grp_take;
	assign feed_stall = valid_s1 && !grp_take;
	assign accept     = feed_valid && !feed_stall;

	// Scan the registered word against the held sequence
	always_comb begin
		cur.held    = held_q;
		cur.held_n  = held_n_q;
		cur.seq_len = seq_len_q;
		cur.kept    = '0;
		cur.kept_n  = '0;
		nxt         = scan_word(cur, word_s1);
	end

	assign grp_valid     = valid_s1;
	assign grp.kept      = nxt.kept;
	assign grp.kept_n    = nxt.kept_n;
	assign grp.text_end  = word_s1.text_end;

	// Track input register occupancy and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			held_n_q  <= '0;
			seq_len_q <= '0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) begin
				held_n_q  <= nxt.held_n;
				seq_len_q <= nxt.seq_len;
			end
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (accept) word_s1 <= feed_word;
		if (adv) held_q <= nxt.held;
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && word_s1.text_end |=> held_n_q == 2'd0 && seq_len_q == 3'd0)
		else $error("sequence still pending after end of text");

	a_len_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(held_n_q == 2'd0) == (seq_len_q == 3'd0))
		else $error("held count and sequence length disagree");

	a_held_short: assert property (@(posedge clk) disable iff (!arst_n)
		held_n_q != 2'd0 |-> {1'b0, held_n_q} < seq_len_q)
		else $error("held bytes reach sequence length");

endmodule

`default_nettype wire

// ===== sv/ues_serial.sv =====
`default_nettype none

module ues_serial (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          grp_valid,
	input  wire ues_pkg::grp_t grp,
	output logic               grp_take,
	output logic               res_valid,
	input  wire logic          res_stall,
	output ues_pkg::out_word_t res_word
);
	import ues_pkg::*;

	logic       valid_s2;
	grp_t       grp_s2;
	logic [1:0] idx_q;
	logic       pop;
	logic       last;

	// Select the current word of the held group
	assign last = (grp_s2.kept_n == 3'd0) || ({1'b0, idx_q} == grp_s2.kept_n - 3'd1);
	assign pop  = valid_s2 && !res_stall;
	assign grp_take = !valid_s2 || (pop && last);

	assign res_valid           = valid_s2;
	assign res_word.out_byte   = (grp_s2.kept_n == 3'd0) ? 8'd0 : grp_s2.kept[idx_q];
	assign res_word.byte_valid = grp_s2.kept_n != 3'd0;
	assign res_word.run_last   = last;
	assign res_word.text_done  = last && grp_s2.text_end;

	// Load a new group or step through the held one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (grp_valid && grp_take) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (pop && last) begin
			valid_s2 <= 1'b0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (grp_valid && grp_take) grp_s2 <= grp;
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && grp_s2.kept_n != 3'd0 |-> {1'b0, idx_q} < grp_s2.kept_n)
		else $error("result index beyond kept count");

	a_group_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> grp_s2.kept_n <= 3'(MaxKept))
		else $error("kept count exceeds group size");

endmodule

`default_nettype wire

// ===== sv/utf8_emoji_stripper_top.sv =====
`default_nettype none

// Channel   Handshake                  Payload
// feed      feed_valid / feed_stall    feed_word  (in_byte, text_end)
// res       res_valid  / res_stall     res_word   (out_byte, byte_valid, run_last, text_done)
//
// One input word is taken per cycle unless feed_stall is high; it yields one to four result
// words, sent one per cycle unless res_stall is high. A word waits in the scan register, then
// its results drain from the group register. Sustained input rate is one word per cycle while
// each word yields one result and res_stall is low; the output port sets the rate otherwise.
// Reset clears the pending sequence and both stage valids; no clearing pass is needed.
// feed_stall rises only while the scan register is full and the group register cannot load.

module utf8_emoji_stripper_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              feed_valid,
	output logic                   feed_stall,
	input  wire ues_pkg::in_word_t feed_word,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output ues_pkg::out_word_t     res_word
);
	import ues_pkg::*;

	logic grp_valid;
	grp_t grp;
	logic grp_take;

	// Collect and filter sequences
	ues_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (feed_valid),
		.feed_stall (feed_stall),
		.feed_word  (feed_word),
		.grp_valid  (grp_valid),
		.grp        (grp),
		.grp_take   (grp_take)
	);

	// Send kept bytes one word at a time
	ues_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp       (grp),
		.grp_take  (grp_take),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

`default_nettype wire
